@@ rtl/core/fdeu_pkg.sv @@
package fdeu_pkg;

  localparam int unsigned CHANNELS   = 3;
  localparam int unsigned TAPS       = 5;
  localparam int unsigned PORT_CH    = 3;
  localparam int unsigned COEF_REGS  = 5;

  localparam int unsigned TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned VAR_W      = 24;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned RATE_CFG_W = 16;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned RATE_W     = 32;
  localparam int unsigned COV_W      = 40;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned MUL_A_W    = SAMPLE_W + 1;
  localparam int unsigned MUL_B_W    = RATE_CFG_W + 1;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned DOT_W      = SAMPLE_W + COEF_W + $clog2(TAPS);
  localparam int unsigned DOT_SPLIT  = (DOT_W + 1) / 2;
  localparam int unsigned DOT_HI_W   = DOT_W - DOT_SPLIT;
  localparam int unsigned ACC_W      = DOT_W + RATE_CFG_W + 1;
  localparam int unsigned GAIN_SPLIT = GAIN_W / 2;
  localparam int unsigned FRAC_BITS  = 14;

  localparam int unsigned PC_W       = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [VAR_W-1:0]    var_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [RATE_W-1:0]   rate_t;
  typedef logic        [COV_W-1:0]    cov_t;

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
      {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam rate_t RATE_MAX = {1'b0, {(RATE_W - 1){1'b1}}};
  localparam rate_t RATE_MIN = {1'b1, {(RATE_W - 1){1'b0}}};
  localparam cov_t  COV_MAX  = {COV_W{1'b1}};
  localparam cov_t  COV_RESET = COV_W'(65536);
  localparam logic [RATE_CFG_W-1:0] RATE_RESET = RATE_CFG_W'(1000);

  localparam logic [PC_W-1:0] PC_MAC_FIRST = PC_W'(0);
  localparam logic [PC_W-1:0] PC_MAC_LOOP  = PC_W'(1);
  localparam logic [PC_W-1:0] PC_MAC_LAST  = PC_W'(2);
  localparam logic [PC_W-1:0] PC_DOT_LO    = PC_W'(3);
  localparam logic [PC_W-1:0] PC_DOT_HI    = PC_W'(4);
  localparam logic [PC_W-1:0] PC_RATE_SUM  = PC_W'(5);
  localparam logic [PC_W-1:0] PC_RATE_WR   = PC_W'(6);
  localparam logic [PC_W-1:0] PC_COV_SUM   = PC_W'(7);
  localparam logic [PC_W-1:0] PC_COV_WR    = PC_W'(8);

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TAP,
    MUL_DOT_LO,
    MUL_DOT_HI,
    MUL_COV_LO,
    MUL_COV_HI
  } mul_op_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_DOT_HI,
    ACC_ADD_COV_HI
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_TAP_MORE,
    JMP_CHAN_MORE
  } jmp_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_RUN,
    SQ_EMIT
  } seq_state_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_WARM    = 2'd0,
    STATUS_UPDATED = 2'd1,
    STATUS_STALE   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_0,
    CFG_COEF_1,
    CFG_COEF_2,
    CFG_COEF_3,
    CFG_COEF_4,
    CFG_SAMPLE_RATE,
    CFG_NOISE_GAIN
  } cfg_idx_e;

  typedef struct packed {
    mul_op_e mul_op;
    acc_op_e acc_op;
    logic    wr_rate;
    logic    wr_cov;
  } dp_ctrl_t;

  typedef struct packed {
    dp_ctrl_t        dp;
    logic            tap_inc;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic fill;
    logic shift;
  } load_t;

  localparam dp_ctrl_t DP_NOP = '{
    mul_op:  MUL_NONE,
    acc_op:  ACC_HOLD,
    wr_rate: 1'b0,
    wr_cov:  1'b0
  };

endpackage

@@ rtl/core/fdeu_ucode_rom.sv @@
module fdeu_ucode_rom import fdeu_pkg::*; (
  input  logic [PC_W-1:0] pc_i,
  output ucode_t          uc_o
);

  always_comb begin
    uc_o = '{dp: DP_NOP, tap_inc: 1'b0, jmp: JMP_NONE, target: PC_MAC_FIRST};
    case (pc_i)
      PC_MAC_FIRST: begin
        uc_o.dp.mul_op = MUL_TAP;
        uc_o.dp.acc_op = ACC_CLR;
        uc_o.tap_inc   = 1'b1;
      end
      PC_MAC_LOOP: begin
        uc_o.dp.mul_op = MUL_TAP;
        uc_o.dp.acc_op = ACC_ADD;
        uc_o.tap_inc   = 1'b1;
        uc_o.jmp       = JMP_TAP_MORE;
        uc_o.target    = PC_MAC_LOOP;
      end
      PC_MAC_LAST: begin
        uc_o.dp.acc_op = ACC_ADD;
      end
      PC_DOT_LO: begin
        uc_o.dp.mul_op = MUL_DOT_LO;
      end
      PC_DOT_HI: begin
        uc_o.dp.mul_op = MUL_DOT_HI;
        uc_o.dp.acc_op = ACC_LOAD;
      end
      PC_RATE_SUM: begin
        uc_o.dp.mul_op = MUL_COV_LO;
        uc_o.dp.acc_op = ACC_ADD_DOT_HI;
      end
      PC_RATE_WR: begin
        uc_o.dp.mul_op  = MUL_COV_HI;
        uc_o.dp.acc_op  = ACC_LOAD;
        uc_o.dp.wr_rate = 1'b1;
      end
      PC_COV_SUM: begin
        uc_o.dp.acc_op = ACC_ADD_COV_HI;
      end
      PC_COV_WR: begin
        uc_o.dp.wr_cov = 1'b1;
        uc_o.jmp       = JMP_CHAN_MORE;
        uc_o.target    = PC_MAC_FIRST;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/fdeu_seq.sv @@
module fdeu_seq import fdeu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [TIME_W-1:0] time_stamp_i,
  input  logic              slot_free_i,
  output logic              emit_o,
  output status_e           status_o,
  output load_t             load_o,
  output logic [PC_W-1:0]   pc_o,
  input  ucode_t            uc_i,
  output dp_ctrl_t          ctrl_o,
  output logic [TAP_W-1:0]  tap_o,
  output logic [CH_W-1:0]   chan_o
);

  seq_state_e        state_q, state_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [TAP_W-1:0]  tap_q, tap_d;
  logic [CH_W-1:0]   chan_q, chan_d;
  logic              primed_q, primed_d;
  logic [TIME_W-1:0] last_time_q, last_time_d;
  status_e           status_q, status_d;
  logic              tap_last;
  logic              chan_last;

  assign tap_last  = (tap_q == TAP_W'(TAPS - 1));
  assign chan_last = (chan_q == CH_W'(CHANNELS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SQ_IDLE;
      pc_q        <= PC_MAC_FIRST;
      tap_q       <= '0;
      chan_q      <= '0;
      primed_q    <= 1'b0;
      last_time_q <= '0;
      status_q    <= STATUS_WARM;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      tap_q       <= tap_d;
      chan_q      <= chan_d;
      primed_q    <= primed_d;
      last_time_q <= last_time_d;
      status_q    <= status_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    tap_d       = tap_q;
    chan_d      = chan_q;
    primed_d    = primed_q;
    last_time_d = last_time_q;
    status_d    = status_q;
    load_o      = '0;
    ctrl_o      = DP_NOP;
    emit_o      = 1'b0;
    case (state_q)
      SQ_IDLE: begin
        if (in_valid_i) begin
          state_d = SQ_EMIT;
          if (!primed_q) begin
            load_o.fill = 1'b1;
            primed_d    = 1'b1;
            last_time_d = time_stamp_i;
            status_d    = STATUS_WARM;
          end else if (time_stamp_i <= last_time_q) begin
            status_d = STATUS_STALE;
          end else begin
            load_o.shift = 1'b1;
            last_time_d  = time_stamp_i;
            status_d     = STATUS_UPDATED;
            state_d      = SQ_RUN;
          end
        end
      end
      SQ_RUN: begin
        ctrl_o = uc_i.dp;
        pc_d   = pc_q + PC_W'(1);
        if (uc_i.tap_inc) begin
          tap_d = tap_last ? '0 : tap_q + TAP_W'(1);
        end
        case (uc_i.jmp)
          JMP_TAP_MORE: begin
            if (!tap_last) begin
              pc_d = uc_i.target;
            end
          end
          JMP_CHAN_MORE: begin
            if (!chan_last) begin
              pc_d   = uc_i.target;
              chan_d = chan_q + CH_W'(1);
            end else begin
              pc_d    = PC_MAC_FIRST;
              chan_d  = '0;
              state_d = SQ_EMIT;
            end
          end
          default: begin
          end
        endcase
      end
      SQ_EMIT: begin
        if (slot_free_i) begin
          emit_o  = 1'b1;
          state_d = SQ_IDLE;
        end
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != SQ_IDLE);
  assign status_o   = status_q;
  assign pc_o       = pc_q;
  assign tap_o      = tap_q;
  assign chan_o     = chan_q;

endmodule

@@ rtl/core/fdeu_dp.sv @@
module fdeu_dp import fdeu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  load_t                 load_i,
  input  dp_ctrl_t              ctrl_i,
  input  logic [TAP_W-1:0]      tap_i,
  input  logic [CH_W-1:0]       chan_i,
  input  sample_t               meas_i [CHANNELS],
  input  var_t                  var_i [CHANNELS],
  input  coef_t                 coef_i [TAPS],
  input  logic [RATE_CFG_W-1:0] sample_rate_i,
  input  logic [GAIN_W-1:0]     noise_gain_i,
  output rate_t                 rate_o [CHANNELS],
  output cov_t                  cov_o [CHANNELS]
);

  sample_t                   tap_q [CHANNELS][TAPS];
  var_t                      var_q [CHANNELS];
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  rate_t                     rate_q [CHANNELS];
  cov_t                      cov_q [CHANNELS];

  sample_t                   tap_sel;
  coef_t                     coef_sel;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   rnd_sum;
  logic signed [ACC_W-1:0]   rnd_shr;
  logic                      rate_fits;
  rate_t                     rate_sat;
  cov_t                      cov_sat;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (load_i.fill) begin
        for (int t = 0; t < TAPS; t++) begin
          tap_q[c][t] <= meas_i[c];
        end
      end else if (load_i.shift) begin
        tap_q[c][0] <= meas_i[c];
        for (int t = 1; t < TAPS; t++) begin
          tap_q[c][t] <= tap_q[c][t-1];
        end
        var_q[c] <= var_i[c];
      end
    end
  end

  assign tap_sel  = tap_q[chan_i][tap_i];
  assign coef_sel = coef_i[tap_i];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl_i.mul_op)
      MUL_TAP: begin
        mul_a = {{(MUL_A_W - SAMPLE_W){tap_sel[SAMPLE_W-1]}}, tap_sel};
        mul_b = {{(MUL_B_W - COEF_W){coef_sel[COEF_W-1]}}, coef_sel};
      end
      MUL_DOT_LO: begin
        mul_a = {{(MUL_A_W - DOT_SPLIT){1'b0}}, acc_q[DOT_SPLIT-1:0]};
        mul_b = {{(MUL_B_W - RATE_CFG_W){1'b0}}, sample_rate_i};
      end
      MUL_DOT_HI: begin
        mul_a = {{(MUL_A_W - DOT_HI_W){acc_q[DOT_W-1]}}, acc_q[DOT_W-1:DOT_SPLIT]};
        mul_b = {{(MUL_B_W - RATE_CFG_W){1'b0}}, sample_rate_i};
      end
      MUL_COV_LO: begin
        mul_a = {{(MUL_A_W - VAR_W){1'b0}}, var_q[chan_i]};
        mul_b = {{(MUL_B_W - GAIN_SPLIT){1'b0}}, noise_gain_i[GAIN_SPLIT-1:0]};
      end
      MUL_COV_HI: begin
        mul_a = {{(MUL_A_W - VAR_W){1'b0}}, var_q[chan_i]};
        mul_b = {{(MUL_B_W - (GAIN_W - GAIN_SPLIT)){1'b0}},
                 noise_gain_i[GAIN_W-1:GAIN_SPLIT]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_op != MUL_NONE) begin
      prod_q <= mul_a * mul_b;
    end
  end

  assign prod_ext = {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    case (ctrl_i.acc_op)
      ACC_CLR:        acc_d = '0;
      ACC_LOAD:       acc_d = prod_ext;
      ACC_ADD:        acc_d = acc_q + prod_ext;
      ACC_ADD_DOT_HI: acc_d = acc_q + (prod_ext <<< DOT_SPLIT);
      ACC_ADD_COV_HI: acc_d = acc_q + (prod_ext <<< GAIN_SPLIT);
      default:        acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign rnd_sum   = acc_q + ROUND_HALF;
  assign rnd_shr   = rnd_sum >>> FRAC_BITS;
  assign rate_fits = (&rnd_shr[ACC_W-1:RATE_W-1]) | ~(|rnd_shr[ACC_W-1:RATE_W-1]);
  assign rate_sat  = rate_fits ? rnd_shr[RATE_W-1:0]
                               : (rnd_shr[ACC_W-1] ? RATE_MIN : RATE_MAX);
  assign cov_sat   = (|acc_q[ACC_W-1:COV_W]) ? COV_MAX : acc_q[COV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        rate_q[c] <= '0;
        cov_q[c]  <= COV_RESET;
      end
    end else begin
      if (ctrl_i.wr_rate) begin
        rate_q[chan_i] <= rate_sat;
      end
      if (ctrl_i.wr_cov) begin
        cov_q[chan_i] <= cov_sat;
      end
    end
  end

  assign rate_o = rate_q;
  assign cov_o  = cov_q;

endmodule

@@ rtl/core/fir_derivative_estimator_unit.sv @@
// A warm-start or stale-timestamp item goes from acceptance straight to the emit state; an
// updating item first runs the microcode program once per channel, then reaches emit. In emit
// the result is registered into the output slot once that slot is free. No new item is taken
// until the unit is back in idle, as the single shared multiplier is stepped through per channel.
// Reset (rst_ni low, asynchronous): held rates 0, held covariances 1.0, coefficients 0,
// sample rate 1000, noise gain 0; the first item after reset primes the delay lines.
module fir_derivative_estimator_unit import fdeu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [SAMPLE_W-1:0]   meas_x_i,
  input  logic [SAMPLE_W-1:0]   meas_y_i,
  input  logic [SAMPLE_W-1:0]   meas_z_i,
  input  logic [VAR_W-1:0]      var_x_i,
  input  logic [VAR_W-1:0]      var_y_i,
  input  logic [VAR_W-1:0]      var_z_i,
  input  logic [TIME_W-1:0]     time_stamp_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [RATE_W-1:0]     rate_x_o,
  output logic [RATE_W-1:0]     rate_y_o,
  output logic [RATE_W-1:0]     rate_z_o,
  output logic [COV_W-1:0]      cov_x_o,
  output logic [COV_W-1:0]      cov_y_o,
  output logic [COV_W-1:0]      cov_z_o,
  output logic [STATUS_W-1:0]   status_o
);

  coef_t                 coef_q [COEF_REGS];
  logic [RATE_CFG_W-1:0] sample_rate_q;
  logic [GAIN_W-1:0]     noise_gain_q;

  sample_t               meas_all [PORT_CH];
  var_t                  var_all [PORT_CH];
  sample_t               meas_use [CHANNELS];
  var_t                  var_use [CHANNELS];
  coef_t                 coef_use [TAPS];
  rate_t                 rate_dp [CHANNELS];
  cov_t                  cov_dp [CHANNELS];
  rate_t                 rate_all [PORT_CH];
  cov_t                  cov_all [PORT_CH];

  logic                  out_valid_q;
  rate_t                 rate_out_q [PORT_CH];
  cov_t                  cov_out_q [PORT_CH];
  status_e               status_out_q;

  logic                  slot_free;
  logic                  emit;
  status_e               status;
  load_t                 load;
  logic [PC_W-1:0]       pc;
  ucode_t                uc;
  dp_ctrl_t              ctrl;
  logic [TAP_W-1:0]      tap;
  logic [CH_W-1:0]       chan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COEF_REGS; i++) begin
        coef_q[i] <= '0;
      end
      sample_rate_q <= RATE_RESET;
      noise_gain_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COEF_0:      coef_q[0]     <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_1:      coef_q[1]     <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_2:      coef_q[2]     <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_3:      coef_q[3]     <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_4:      coef_q[4]     <= cfg_data_i[COEF_W-1:0];
        CFG_SAMPLE_RATE: sample_rate_q <= cfg_data_i[RATE_CFG_W-1:0];
        CFG_NOISE_GAIN:  noise_gain_q  <= cfg_data_i[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign meas_all[0] = meas_x_i;
  assign meas_all[1] = meas_y_i;
  assign meas_all[2] = meas_z_i;
  assign var_all[0]  = var_x_i;
  assign var_all[1]  = var_y_i;
  assign var_all[2]  = var_z_i;

  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    assign coef_use[t] = coef_q[t];
  end

  for (genvar c = 0; c < PORT_CH; c++) begin : g_ch
    if (c < CHANNELS) begin : g_used
      assign meas_use[c] = meas_all[c];
      assign var_use[c]  = var_all[c];
      assign rate_all[c] = rate_dp[c];
      assign cov_all[c]  = cov_dp[c];
    end else begin : g_unused
      assign rate_all[c] = '0;
      assign cov_all[c]  = '0;
    end
  end

  fdeu_ucode_rom u_rom (
    .pc_i (pc),
    .uc_o (uc)
  );

  fdeu_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .time_stamp_i (time_stamp_i),
    .slot_free_i  (slot_free),
    .emit_o       (emit),
    .status_o     (status),
    .load_o       (load),
    .pc_o         (pc),
    .uc_i         (uc),
    .ctrl_o       (ctrl),
    .tap_o        (tap),
    .chan_o       (chan)
  );

  fdeu_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .ctrl_i        (ctrl),
    .tap_i         (tap),
    .chan_i        (chan),
    .meas_i        (meas_use),
    .var_i         (var_use),
    .coef_i        (coef_use),
    .sample_rate_i (sample_rate_q),
    .noise_gain_i  (noise_gain_q),
    .rate_o        (rate_dp),
    .cov_o         (cov_dp)
  );

  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rate_out_q   <= rate_all;
      cov_out_q    <= cov_all;
      status_out_q <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rate_x_o    = rate_out_q[0];
  assign rate_y_o    = rate_out_q[1];
  assign rate_z_o    = rate_out_q[2];
  assign cov_x_o     = cov_out_q[0];
  assign cov_y_o     = cov_out_q[1];
  assign cov_z_o     = cov_out_q[2];
  assign status_o    = status_out_q;

endmodule

@@ dv/tb.sv @@
module tb;
  import fdeu_pkg::*;

  typedef struct packed {
    sample_t [PORT_CH-1:0] meas;
    var_t    [PORT_CH-1:0] variance;
    logic    [TIME_W-1:0]  stamp;
  } sample_item_t;

  typedef struct packed {
    rate_t   [PORT_CH-1:0] rate;
    cov_t    [PORT_CH-1:0] cov;
    status_e               status;
  } estimate_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   meas_x_i = '0;
  logic [SAMPLE_W-1:0]   meas_y_i = '0;
  logic [SAMPLE_W-1:0]   meas_z_i = '0;
  logic [VAR_W-1:0]      var_x_i = '0;
  logic [VAR_W-1:0]      var_y_i = '0;
  logic [VAR_W-1:0]      var_z_i = '0;
  logic [TIME_W-1:0]     time_stamp_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [RATE_W-1:0]     rate_x_o;
  logic [RATE_W-1:0]     rate_y_o;
  logic [RATE_W-1:0]     rate_z_o;
  logic [COV_W-1:0]      cov_x_o;
  logic [COV_W-1:0]      cov_y_o;
  logic [COV_W-1:0]      cov_z_o;
  logic [STATUS_W-1:0]   status_o;

  // derivative predictor state and register mirror
  sample_t               delay_taps [CHANNELS][TAPS];
  rate_t                 held_rate [PORT_CH] = '{default: '0};
  cov_t                  held_cov [PORT_CH] = '{default: COV_RESET};
  logic [TIME_W-1:0]     last_stamp = '0;
  bit                    primed = 1'b0;
  coef_t                 coef_q [COEF_REGS] = '{default: '0};
  logic [RATE_CFG_W-1:0] rate_hz = RATE_RESET;
  logic [GAIN_W-1:0]     gain_q = '0;

  estimate_t             pending_estimates [$];
  int                    mismatch_count = 0;
  int                    hold_left = 0;
  bit                    tx_idle_on = 1'b1;
  bit                    rx_idle_on = 1'b1;

  fir_derivative_estimator_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .meas_x_i     (meas_x_i),
    .meas_y_i     (meas_y_i),
    .meas_z_i     (meas_z_i),
    .var_x_i      (var_x_i),
    .var_y_i      (var_y_i),
    .var_z_i      (var_z_i),
    .time_stamp_i (time_stamp_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rate_x_o     (rate_x_o),
    .rate_y_o     (rate_y_o),
    .rate_z_o     (rate_z_o),
    .cov_x_o      (cov_x_o),
    .cov_y_o      (cov_y_o),
    .cov_z_o      (cov_z_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void predict_estimate(input sample_item_t it);
    estimate_t   e;
    longint      dot;
    logic [63:0] prod;
    status_e     st;
    e = '0;
    if (!primed) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int t = 0; t < TAPS; t++) begin
          delay_taps[c][t] = it.meas[c];
        end
      end
      last_stamp = it.stamp;
      primed = 1'b1;
      st = STATUS_WARM;
    end else if (it.stamp <= last_stamp) begin
      st = STATUS_STALE;
    end else begin
      last_stamp = it.stamp;
      for (int c = 0; c < CHANNELS; c++) begin
        for (int t = TAPS - 1; t > 0; t--) begin
          delay_taps[c][t] = delay_taps[c][t-1];
        end
        delay_taps[c][0] = it.meas[c];
        dot = 0;
        for (int t = 0; t < TAPS; t++) begin
          dot += longint'(coef_q[t]) * longint'(delay_taps[c][t]);
        end
        dot = dot * longint'(rate_hz);
        dot = (dot + 64'sd8192) >>> FRAC_BITS;
        if (dot > 64'sd2147483647) begin
          held_rate[c] = RATE_MAX;
        end else if (dot < -64'sd2147483648) begin
          held_rate[c] = RATE_MIN;
        end else begin
          held_rate[c] = rate_t'(dot);
        end
        prod = 64'(it.variance[c]) * 64'(gain_q);
        held_cov[c] = (prod > 64'(COV_MAX)) ? COV_MAX : cov_t'(prod);
      end
      st = STATUS_UPDATED;
    end
    for (int c = 0; c < PORT_CH; c++) begin
      if (c < CHANNELS) begin
        e.rate[c] = held_rate[c];
        e.cov[c]  = held_cov[c];
      end
    end
    e.status = st;
    pending_estimates.push_back(e);
  endfunction

  function automatic sample_item_t make_item(input sample_t x, input sample_t y,
                                             input sample_t z, input var_t vx,
                                             input var_t vy, input var_t vz,
                                             input logic [TIME_W-1:0] stamp);
    sample_item_t it;
    it.meas     = {z, y, x};
    it.variance = {vz, vy, vx};
    it.stamp    = stamp;
    return it;
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return '0;
      default: return $signed(24'($urandom())) >>> $urandom_range(0, 20);
    endcase
  endfunction

  function automatic var_t rand_variance();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return 24'($urandom()) >> $urandom_range(0, 16);
    endcase
  endfunction

  task automatic send_sample(input sample_item_t it);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 10) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    meas_x_i     <= it.meas[0];
    meas_y_i     <= it.meas[1];
    meas_z_i     <= it.meas[2];
    var_x_i      <= it.variance[0];
    var_y_i      <= it.variance[1];
    var_z_i      <= it.variance[2];
    time_stamp_i <= it.stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_estimate(it);
  endtask

  task automatic drain_estimates();
    in_valid_i <= 1'b0;
    while (pending_estimates.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SAMPLE_RATE: rate_hz = data[RATE_CFG_W-1:0];
      CFG_NOISE_GAIN:  gain_q = data[GAIN_W-1:0];
      default:         coef_q[int'(idx)] = data[COEF_W-1:0];
    endcase
  endtask

  task automatic apply_config(input coef_t [COEF_REGS-1:0] w,
                              input logic [RATE_CFG_W-1:0] hz,
                              input logic [GAIN_W-1:0] gain);
    for (int i = 0; i < COEF_REGS; i++) begin
      write_reg(cfg_idx_e'(i), {16'($urandom()), w[i]});
    end
    write_reg(CFG_SAMPLE_RATE, {16'($urandom()), hz});
    write_reg(CFG_NOISE_GAIN, gain);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_config();
    send_sample(make_item(24'sh7FFFFF, 24'sh800000, -24'sd1, '1, '0, 24'd1, 32'd0));
    send_sample(make_item(24'sd5, 24'sd6, 24'sd7, 24'd9, 24'd9, 24'd9, 32'd0));
    send_sample(make_item(rand_sample(), rand_sample(), rand_sample(),
                          '1, 24'd1, '0, 32'd1));
  endtask

  task automatic test_saturation();
    drain_estimates();
    apply_config({COEF_REGS{16'h7FFF}}, 16'hFFFF, 32'hFFFF_FFFF);
    repeat (2) begin
      send_sample(make_item(24'sh7FFFFF, 24'sh800000, '0, '1, 24'd1, '0, last_stamp + 32'd1));
    end
    drain_estimates();
    apply_config({COEF_REGS{16'h8000}}, 16'hFFFF, 32'hFFFF_FFFF);
    repeat (2) begin
      send_sample(make_item(24'sh7FFFFF, 24'sh800000, '0, '1, 24'd1, '0, last_stamp + 32'd3));
    end
  endtask

  task automatic test_rate_extremes();
    drain_estimates();
    apply_config(80'({$urandom(), $urandom(), $urandom()}), 16'd0, 32'd1);
    repeat (2) begin
      send_sample(make_item(rand_sample(), rand_sample(), rand_sample(),
                            '1, rand_variance(), 24'd1, last_stamp + 32'd1));
    end
    drain_estimates();
    apply_config({16'd0, 16'd0, 16'd0, 16'd0, 16'd8192}, 16'd1, 32'd65536);
    send_sample(make_item(24'sd1, -24'sd1, 24'sd3, 24'd2, 24'd1, '1, last_stamp + 32'd2));
    send_sample(make_item(24'sh7FFFFF, 24'sh800000, '0, '1, '0, 24'd3, last_stamp + 32'd1));
  endtask

  task automatic test_random_phases();
    coef_t [COEF_REGS-1:0] w;
    logic [RATE_CFG_W-1:0] hz;
    logic [GAIN_W-1:0]     gain;
    logic [TIME_W-1:0]     stamp;
    int                    style;
    int                    r;
    for (int p = 0; p < 6; p++) begin
      drain_estimates();
      style = $urandom_range(0, 3);
      for (int i = 0; i < COEF_REGS; i++) begin
        case (style)
          0: w[i] = 16'($urandom());
          1: w[i] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          default: w[i] = 16'($urandom_range(0, 8192)) - 16'd4096;
        endcase
      end
      case ($urandom_range(0, 9))
        0: hz = '0;
        1: hz = 16'd1;
        2: hz = '1;
        3, 4, 5: hz = 16'($urandom_range(1, 65535));
        default: hz = 16'($urandom_range(100, 5000));
      endcase
      case ($urandom_range(0, 7))
        0: gain = '0;
        1: gain = '1;
        2, 3: gain = $urandom();
        default: gain = $urandom_range(0, 1 << 18);
      endcase
      apply_config(w, hz, gain);
      tx_idle_on = (p == 1) || (p != 0 && $urandom_range(0, 3) != 0);
      rx_idle_on = (p == 1) || (p != 0 && $urandom_range(0, 3) != 0);
      for (int n = 0; n < 125; n++) begin
        r = $urandom_range(0, 99);
        if (p == 3 && n == 0) begin
          stamp = 32'h8000_0000 | $urandom_range(0, 1 << 24);
        end else if (r < 4) begin
          stamp = last_stamp;
        end else if (r < 10) begin
          stamp = $urandom_range(0, last_stamp);
        end else if (r < 30) begin
          stamp = last_stamp + $urandom_range(1, 3);
        end else if (r < 95) begin
          stamp = last_stamp + $urandom_range(1, 2000);
        end else begin
          stamp = last_stamp + $urandom_range(1, 1 << 20);
        end
        send_sample(make_item(rand_sample(), rand_sample(), rand_sample(),
                              rand_variance(), rand_variance(), rand_variance(), stamp));
      end
    end
  endtask

  task automatic test_timer_wrap();
    drain_estimates();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_sample(make_item(rand_sample(), rand_sample(), rand_sample(),
                          rand_variance(), rand_variance(), rand_variance(), 32'hFFFF_FFFE));
    send_sample(make_item(rand_sample(), rand_sample(), rand_sample(),
                          rand_variance(), rand_variance(), rand_variance(), 32'hFFFF_FFFF));
    send_sample(make_item(rand_sample(), rand_sample(), rand_sample(),
                          rand_variance(), rand_variance(), rand_variance(), 32'd0));
    send_sample(make_item(rand_sample(), rand_sample(), rand_sample(),
                          rand_variance(), rand_variance(), rand_variance(), 32'hFFFF_FFFF));
  endtask

  always @(posedge clk_i) begin : result_check
    estimate_t         want;
    rate_t [PORT_CH-1:0] got_rate;
    cov_t  [PORT_CH-1:0] got_cov;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_estimates.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want     = pending_estimates.pop_front();
        got_rate = {rate_z_o, rate_y_o, rate_x_o};
        got_cov  = {cov_z_o, cov_y_o, cov_x_o};
        for (int c = 0; c < PORT_CH; c++) begin
          if (got_rate[c] !== want.rate[c]) begin
            report_mismatch($sformatf("rate ch%0d got %0d expected %0d", c,
                                      $signed(got_rate[c]), $signed(want.rate[c])));
          end
          if (got_cov[c] !== want.cov[c]) begin
            report_mismatch($sformatf("cov ch%0d got %0h expected %0h", c,
                                      got_cov[c], want.cov[c]));
          end
        end
        if (status_o !== want.status) begin
          report_mismatch($sformatf("status got %0d expected %s", status_o,
                                    want.status.name()));
        end
      end
      hold_left = rx_idle_on ? $urandom_range(0, 10) : 0;
    end else if (out_valid_o && hold_left != 0) begin
      hold_left--;
    end
    out_stall_i <= (hold_left != 0);
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_config();
    test_saturation();
    test_rate_extremes();
    test_random_phases();
    test_timer_wrap();
    drain_estimates();
    repeat (40) @(posedge clk_i);
    if (pending_estimates.size() != 0) begin
      report_mismatch("results still outstanding at end of run");
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ fir_derivative_estimator_unit.f @@
rtl/core/fdeu_pkg.sv
rtl/core/fdeu_ucode_rom.sv
rtl/core/fdeu_seq.sv
rtl/core/fdeu_dp.sv
rtl/core/fir_derivative_estimator_unit.sv
dv/tb.sv
